// ===== rtl/puct_pkg.sv =====
`default_nettype none
package puct_pkg;

   // fixed sizes of the node store
   localparam int ACTION_SLOTS = 64;
   localparam int IDX_W       = 6;
   localparam int VALUE_WIDTH = 32;
   localparam int SUM_W       = VALUE_WIDTH + 8;
   localparam int PRIOR_W     = 16;
   localparam int COUNT_W     = 32;

   // -9999.9 in Q16.16
   localparam logic signed [31:0] MAX_RESET = -32'sd655353446;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_SELECT = 2'd1,
      MODE_BACKUP = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_COUNT_LOW = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_EXPLORATION = 2'd0,
      CSR_VLOSS       = 2'd1,
      CSR_ACTIONS     = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SQRT,
      ST_SCAN_RD,
      ST_SCAN_MUL1,
      ST_SCAN_MUL2,
      ST_SCAN_DSTART,
      ST_SCAN_DIV,
      ST_SCAN_CMP,
      ST_UPD_RD,
      ST_UPD,
      ST_FIN
   } state_type;

   // one entry of the action store
   typedef struct packed {
      logic [PRIOR_W-1:0]      prior;
      logic [COUNT_W-1:0]      count;
      logic signed [SUM_W-1:0] sum;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/puct_ram.sv =====
`default_nettype none
module puct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/puct_divider.sv =====
`default_nettype none
module puct_divider #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numerator,
   input  wire logic [DEN_W-1:0] denominator,
   output logic                  busy,
   output logic [NUM_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   shifted;

   // one quotient bit per cycle, restoring
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = denominator;
         quo_in  = numerator;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/puct_node_select_and_backup_core.sv =====
// select: a square root first, then for each action in use a 56-bit exploration divider
// runs next to a 40-bit value divider; the wider divider sets the pace
// one item at a time; the next item is taken while a result waits in the output register
// reset: synchronous, clears registers to defaults, node totals and maximum tracking;
// the action store holds whatever it held until entries are loaded
`default_nettype none
module puct_node_select_and_backup_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_mode,
   input  wire logic [5:0]                      req_action_index,
   input  wire logic [15:0]                     req_prior_value,
   input  wire logic [7:0]                      req_game_count,
   input  wire logic signed [31:0]              req_path_value,
   input  wire logic [31:0]                     req_action_id,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [5:0]                           rsp_chosen_index,
   output logic [1:0]                           rsp_status,
   output logic [31:0]                          rsp_node_visits,
   output logic signed [31:0]                   rsp_best_value,
   output logic [5:0]                           rsp_best_index,
   output logic                                 rsp_best_valid,
   output logic [31:0]                          rsp_best_action_id,
   input  wire logic                            csr_write_enable,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [15:0]                     csr_write_data
);
   import puct_pkg::*;

   localparam int ACC_W = SUM_W + 2;
   localparam int EXP_W = 56;
   localparam int SCORE_W = SUM_W + 2;

   // configuration
   logic [15:0] expl_ff, vla_ff;
   logic [6:0]  aiu_ff;

   // node totals and maximum tracking
   logic [31:0]        visits_ff, visits_in;
   logic signed [31:0] max_ff, max_in;
   logic [5:0]         max_idx_ff, max_idx_in;
   logic               max_vld_ff, max_vld_in;
   logic [31:0]        max_id_ff, max_id_in;

   // latched request
   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [5:0]         idx_ff, idx_in;
   logic [15:0]        prior_ff, prior_in;
   logic [7:0]         games_ff, games_in;
   logic signed [31:0] pv_ff, pv_in;
   logic [31:0]        aid_ff, aid_in;
   logic [31:0]        vloss_ff, vloss_in;
   logic [1:0]         status_ff, status_in;

   // square root
   logic [47:0] sqx_ff, sqx_in;
   logic [23:0] root_ff, root_in;
   logic [25:0] srem_ff, srem_in;
   logic [4:0]  scnt_ff, scnt_in;
   logic [25:0] sq_shift, sq_trial;

   // scan
   logic [5:0]                i_ff, i_in;
   logic [5:0]                chosen_ff, chosen_in;
   logic [31:0]               cp_ff, cp_in;
   logic [COUNT_W-1:0]        n_ff, n_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [EXP_W-1:0]          unum_ff, unum_in;
   logic signed [SCORE_W-1:0] best_ff, best_in, score;
   logic signed [SUM_W:0]     q_val;
   logic [SUM_W-1:0]          sum_mag;

   // dividers
   logic                 div_start, ediv_busy, qdiv_busy;
   logic [EXP_W-1:0]     ediv_quo;
   logic [SUM_W-1:0]     qdiv_quo;

   // store
   logic      ram_we;
   logic [5:0] ram_waddr, ram_raddr;
   entry_type ram_wdata, ram_rdata;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         o_chosen_ff, o_chosen_in;
   logic [1:0]         o_status_ff, o_status_in;
   logic [31:0]        o_visits_ff, o_visits_in;
   logic signed [31:0] o_best_ff, o_best_in;
   logic [5:0]         o_bidx_ff, o_bidx_in;
   logic               o_bvld_ff, o_bvld_in;
   logic [31:0]        o_bid_ff, o_bid_in;

   logic [6:0]             used;
   logic                   in_range;
   logic signed [33:0]     nc, vt_dec;
   logic [32:0]            cnt_inc, vt_inc;
   logic signed [ACC_W-1:0] acc;

   puct_ram #(.WIDTH($bits(entry_type)), .DEPTH(ACTION_SLOTS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   puct_divider #(.NUM_W(EXP_W), .DEN_W(COUNT_W + 1)) u_exp_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (unum_ff),
      .denominator ({1'b0, n_ff} + 33'd1),
      .busy        (ediv_busy),
      .quotient    (ediv_quo)
   );

   puct_divider #(.NUM_W(SUM_W), .DEN_W(COUNT_W)) u_q_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (sum_mag),
      .denominator (n_ff),
      .busy        (qdiv_busy),
      .quotient    (qdiv_quo)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expl_ff <= 16'd256;
         vla_ff  <= 16'd256;
         aiu_ff  <= 7'd64;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPLORATION: expl_ff <= csr_write_data;
            CSR_VLOSS:       vla_ff  <= csr_write_data;
            CSR_ACTIONS:     aiu_ff  <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // clamp actions in use
   always_comb begin
      if (aiu_ff == 7'd0) begin
         used = 7'd1;
      end else if (aiu_ff > 7'(ACTION_SLOTS)) begin
         used = 7'(ACTION_SLOTS);
      end else begin
         used = aiu_ff;
      end
   end

   assign in_range  = {1'b0, idx_ff} < used;
   assign req_ready = (state_ff == ST_IDLE);
   assign ram_raddr = (state_ff inside {ST_UPD_RD, ST_UPD}) ? chosen_ff : i_ff;
   assign div_start = (state_ff == ST_SCAN_DSTART);
   assign sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // square root step terms
   assign sq_shift = {srem_ff[23:0], sqx_ff[47:46]};
   assign sq_trial = {root_ff, 2'b01};

   // score of current action
   always_comb begin
      if (n_ff == '0) begin
         q_val = '0;
      end else if (sum_ff[SUM_W-1]) begin
         q_val = -$signed({1'b0, qdiv_quo});
      end else begin
         q_val = $signed({1'b0, qdiv_quo});
      end
      score = SCORE_W'(q_val) + $signed({2'b00, ediv_quo[EXP_W-1:16]});
   end

   // update arithmetic
   always_comb begin
      cnt_inc = {1'b0, ram_rdata.count} + 33'(games_ff);
      vt_inc  = {1'b0, visits_ff} + 33'(games_ff);
      nc      = $signed({2'b00, ram_rdata.count}) + 34'sd1 - $signed({26'd0, games_ff});
      vt_dec  = $signed({2'b00, visits_ff}) + 34'sd1 - $signed({26'd0, games_ff});
      if (mode_ff == MODE_SELECT) begin
         acc = ACC_W'(ram_rdata.sum) - $signed({10'd0, vloss_ff});
      end else begin
         acc = ACC_W'(ram_rdata.sum) + $signed({10'd0, vloss_ff}) + ACC_W'(pv_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      idx_in     = idx_ff;
      prior_in   = prior_ff;
      games_in   = games_ff;
      pv_in      = pv_ff;
      aid_in     = aid_ff;
      vloss_in   = vloss_ff;
      status_in  = status_ff;
      visits_in  = visits_ff;
      max_in     = max_ff;
      max_idx_in = max_idx_ff;
      max_vld_in = max_vld_ff;
      max_id_in  = max_id_ff;
      sqx_in     = sqx_ff;
      root_in    = root_ff;
      srem_in    = srem_ff;
      scnt_in    = scnt_ff;
      i_in       = i_ff;
      chosen_in  = chosen_ff;
      cp_in      = cp_ff;
      n_in       = n_ff;
      sum_in     = sum_ff;
      unum_in    = unum_ff;
      best_in    = best_ff;
      ram_we     = 1'b0;
      ram_waddr  = chosen_ff;
      ram_wdata  = ram_rdata;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      o_chosen_in  = o_chosen_ff;
      o_status_in  = o_status_ff;
      o_visits_in  = o_visits_ff;
      o_best_in    = o_best_ff;
      o_bidx_in    = o_bidx_ff;
      o_bvld_in    = o_bvld_ff;
      o_bid_in     = o_bid_ff;

      case (state_ff)
         // take a request transfer
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = mode_type'(req_mode);
               idx_in   = req_action_index;
               prior_in = req_prior_value;
               games_in = req_game_count;
               pv_in    = req_path_value;
               aid_in   = req_action_id;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            vloss_in  = {8'd0, 24'(games_ff * vla_ff)} << 8;
            status_in = STATUS_OK;
            chosen_in = idx_ff;
            case (mode_ff)
               MODE_LOAD: begin
                  state_in = ST_FIN;
                  if (!in_range) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     ram_we          = 1'b1;
                     ram_waddr       = idx_ff;
                     ram_wdata.prior = prior_ff;
                     ram_wdata.count = '0;
                     ram_wdata.sum   = '0;
                     if (idx_ff == '0) begin
                        visits_in  = '0;
                        max_in     = MAX_RESET;
                        max_idx_in = '0;
                        max_vld_in = 1'b0;
                        max_id_in  = '0;
                     end
                  end
               end
               MODE_SELECT: begin
                  sqx_in   = {visits_ff, 16'd0};
                  root_in  = '0;
                  srem_in  = '0;
                  scnt_in  = 5'd24;
                  i_in     = '0;
                  state_in = ST_SQRT;
               end
               MODE_BACKUP: begin
                  if (!in_range) begin
                     status_in = STATUS_RANGE;
                     state_in  = ST_FIN;
                  end else begin
                     state_in = ST_UPD_RD;
                  end
               end
               default: state_in = ST_FIN;
            endcase
         end
         // one root bit per cycle
         ST_SQRT: begin
            sqx_in = {sqx_ff[45:0], 2'b00};
            if (sq_shift >= sq_trial) begin
               srem_in = sq_shift - sq_trial;
               root_in = {root_ff[22:0], 1'b1};
            end else begin
               srem_in = sq_shift;
               root_in = {root_ff[22:0], 1'b0};
            end
            scnt_in = scnt_ff - 1'b1;
            if (scnt_ff == 5'd1) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_MUL1;
         ST_SCAN_MUL1: begin
            cp_in    = expl_ff * ram_rdata.prior;
            n_in     = ram_rdata.count;
            sum_in   = ram_rdata.sum;
            state_in = ST_SCAN_MUL2;
         end
         ST_SCAN_MUL2: begin
            unum_in  = cp_ff * root_ff;
            state_in = ST_SCAN_DSTART;
         end
         ST_SCAN_DSTART: state_in = ST_SCAN_DIV;
         ST_SCAN_DIV: begin
            if (!ediv_busy && !qdiv_busy) begin
               state_in = ST_SCAN_CMP;
            end
         end
         // keep the first highest score
         ST_SCAN_CMP: begin
            if (i_ff == '0 || score > best_ff) begin
               best_in   = score;
               chosen_in = i_ff;
            end
            if ({1'b0, i_ff} + 7'd1 == used) begin
               state_in = ST_UPD_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_UPD_RD: state_in = ST_UPD;
         // read-modify-write of the target entry
         ST_UPD: begin
            state_in = ST_FIN;
            if (mode_ff == MODE_SELECT) begin
               ram_we          = 1'b1;
               ram_wdata.count = cnt_inc[32] ? '1 : cnt_inc[31:0];
               visits_in       = vt_inc[32] ? '1 : vt_inc[31:0];
            end else if (nc < 34'sd1) begin
               status_in = STATUS_COUNT_LOW;
            end else begin
               ram_we          = 1'b1;
               ram_wdata.count = nc[32] ? '1 : nc[31:0];
               if (vt_dec < 0) begin
                  visits_in = '0;
               end else if (vt_dec[32]) begin
                  visits_in = '1;
               end else begin
                  visits_in = vt_dec[31:0];
               end
               if (pv_ff > max_ff) begin
                  max_in     = pv_ff;
                  max_idx_in = idx_ff;
                  max_vld_in = 1'b1;
                  max_id_in  = aid_ff;
               end
            end
            if (acc[ACC_W-1:SUM_W-1] == '0 || acc[ACC_W-1:SUM_W-1] == '1) begin
               ram_wdata.sum = acc[SUM_W-1:0];
            end else if (acc[ACC_W-1]) begin
               ram_wdata.sum = {1'b1, {(SUM_W-1){1'b0}}};
            end else begin
               ram_wdata.sum = {1'b0, {(SUM_W-1){1'b1}}};
            end
         end
         // hand the result to the output register
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_chosen_in  = (mode_ff == MODE_SELECT) ? chosen_ff : '0;
               o_status_in  = status_ff;
               o_visits_in  = visits_ff;
               o_best_in    = max_ff;
               o_bidx_in    = max_idx_ff;
               o_bvld_in    = max_vld_ff;
               o_bid_in     = max_id_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         visits_ff    <= '0;
         max_ff       <= MAX_RESET;
         max_idx_ff   <= '0;
         max_vld_ff   <= 1'b0;
         max_id_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         visits_ff    <= visits_in;
         max_ff       <= max_in;
         max_idx_ff   <= max_idx_in;
         max_vld_ff   <= max_vld_in;
         max_id_ff    <= max_id_in;
      end
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      prior_ff    <= prior_in;
      games_ff    <= games_in;
      pv_ff       <= pv_in;
      aid_ff      <= aid_in;
      vloss_ff    <= vloss_in;
      status_ff   <= status_in;
      sqx_ff      <= sqx_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      scnt_ff     <= scnt_in;
      i_ff        <= i_in;
      chosen_ff   <= chosen_in;
      cp_ff       <= cp_in;
      n_ff        <= n_in;
      sum_ff      <= sum_in;
      unum_ff     <= unum_in;
      best_ff     <= best_in;
      o_chosen_ff <= o_chosen_in;
      o_status_ff <= o_status_in;
      o_visits_ff <= o_visits_in;
      o_best_ff   <= o_best_in;
      o_bidx_ff   <= o_bidx_in;
      o_bvld_ff   <= o_bvld_in;
      o_bid_ff    <= o_bid_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_index   = o_chosen_ff;
   assign rsp_status         = o_status_ff;
   assign rsp_node_visits    = o_visits_ff;
   assign rsp_best_value     = o_best_ff;
   assign rsp_best_index     = o_bidx_ff;
   assign rsp_best_valid     = o_bvld_ff;
   assign rsp_best_action_id = o_bid_ff;
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import puct_pkg::*;

   typedef struct {
      mode_type           mode;
      logic [5:0]         index;
      logic [15:0]        prior;
      logic [7:0]         games;
      logic signed [31:0] path;
      logic [31:0]        aid;
   } node_req_type;

   typedef struct {
      logic [5:0]         chosen;
      status_type         status;
      logic [31:0]        visits;
      logic signed [31:0] best_value;
      logic [5:0]         best_index;
      logic               best_valid;
      logic [31:0]        best_aid;
   } node_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   wire logic           req_ready;
   logic [1:0]          req_mode = 2'd0;
   logic [5:0]          req_action_index = 6'd0;
   logic [15:0]         req_prior_value = 16'd0;
   logic [7:0]          req_game_count = 8'd0;
   logic signed [31:0]  req_path_value = 32'sd0;
   logic [31:0]         req_action_id = 32'd0;
   wire logic           rsp_valid;
   logic                rsp_ready = 1'b0;
   wire logic [5:0]     rsp_chosen_index;
   wire logic [1:0]     rsp_status;
   wire logic [31:0]    rsp_node_visits;
   wire logic signed [31:0] rsp_best_value;
   wire logic [5:0]     rsp_best_index;
   wire logic           rsp_best_valid;
   wire logic [31:0]    rsp_best_action_id;
   logic                csr_write_enable = 1'b0;
   logic [1:0]          csr_index = 2'd0;
   logic [15:0]         csr_write_data = 16'd0;

   puct_node_select_and_backup_core dut (.*);

   always #2 clock = ~clock;

   // node statistics as predicted
   logic [15:0]        prior_mem [ACTION_SLOTS];
   logic [31:0]        count_mem [ACTION_SLOTS];
   longint             sum_mem   [ACTION_SLOTS];
   logic [31:0]        visit_sum;
   logic signed [31:0] top_value;
   logic [5:0]         top_index;
   logic               top_valid;
   logic [31:0]        top_aid;
   logic [15:0]        weight_c;
   logic [15:0]        vloss_step;
   logic [6:0]         actions_cfg;

   node_req_type pending_reqs[$];
   node_rsp_type awaited_rsps[$];
   int        errors = 0;
   int        send_idle = 1;
   int        recv_idle = 1;
   bit        long_hold_go = 1'b0;
   bit        long_hold_done = 1'b0;
   int        gap_left = 0;
   int        hold_left = 0;

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int b = 27; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp_count(longint v);
      if (v < 0) return 32'd0;
      if (v > 64'sh0FFFF_FFFF) return 32'hFFFF_FFFF;
      return v[31:0];
   endfunction

   function automatic longint clamp_sum(longint v);
      longint hi;
      hi = (64'sd1 <<< (SUM_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic int actions_live();
      if (actions_cfg == 0) return 1;
      if (actions_cfg > ACTION_SLOTS) return ACTION_SLOTS;
      return actions_cfg;
   endfunction

   function automatic void clear_top();
      top_value = MAX_RESET;
      top_index = 0;
      top_valid = 0;
      top_aid   = 0;
   endfunction

   // advance the node statistics by one item and form its result
   function automatic node_rsp_type node_update(node_req_type r);
      node_rsp_type o;
      int eff;
      longint vloss, nc, q, sc, best;
      longint unsigned sq, u, n;
      o.chosen = 0;
      o.status = STATUS_OK;
      eff = actions_live();
      vloss = longint'(r.games) * longint'(vloss_step) * 256;
      best = 0;
      case (r.mode)
         MODE_LOAD: begin
            if (r.index >= eff) o.status = STATUS_RANGE;
            else begin
               prior_mem[r.index] = r.prior;
               count_mem[r.index] = 0;
               sum_mem[r.index] = 0;
               if (r.index == 0) begin
                  visit_sum = 0;
                  clear_top();
               end
            end
         end
         MODE_SELECT: begin
            sq = int_root(longint'(visit_sum) << 16);
            for (int i = 0; i < eff; i++) begin
               n = longint'(count_mem[i]);
               u = longint'(weight_c) * longint'(prior_mem[i]) * sq;
               u = (u / (n + 1)) >> 16;
               q = (n != 0) ? sum_mem[i] / longint'(n) : 0;
               sc = q + longint'(u);
               if (i == 0 || sc > best) begin
                  best = sc;
                  o.chosen = 6'(i);
               end
            end
            count_mem[o.chosen] = clamp_count(longint'(count_mem[o.chosen]) + r.games);
            sum_mem[o.chosen] = clamp_sum(sum_mem[o.chosen] - vloss);
            visit_sum = clamp_count(longint'(visit_sum) + r.games);
         end
         MODE_BACKUP: begin
            if (r.index >= eff) o.status = STATUS_RANGE;
            else begin
               nc = longint'(count_mem[r.index]) + 1 - longint'(r.games);
               if (nc < 1) o.status = STATUS_COUNT_LOW;
               else begin
                  count_mem[r.index] = clamp_count(nc);
                  if (longint'(r.path) > longint'(top_value)) begin
                     top_value = r.path;
                     top_index = r.index;
                     top_valid = 1;
                     top_aid   = r.aid;
                  end
                  sum_mem[r.index] = clamp_sum(sum_mem[r.index] + vloss + longint'(r.path));
                  visit_sum = clamp_count(longint'(visit_sum) + 1 - longint'(r.games));
               end
            end
         end
         default: ;
      endcase
      o.visits     = visit_sum;
      o.best_value = top_value;
      o.best_index = top_index;
      o.best_valid = top_valid;
      o.best_aid   = top_aid;
      return o;
   endfunction

   function automatic int pick_gap(int idle);
      int r;
      if (!idle) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // queue one item and its predicted result; returns the picked action
   task automatic issue(mode_type m, logic [5:0] idx, logic [15:0] pr, logic [7:0] g,
                        logic signed [31:0] pv, logic [31:0] aid, output logic [5:0] pick);
      node_req_type r;
      node_rsp_type o;
      r.mode = m; r.index = idx; r.prior = pr; r.games = g; r.path = pv; r.aid = aid;
      o = node_update(r);
      pick = o.chosen;
      pending_reqs.insert(pending_reqs.size(), r);
      awaited_rsps.insert(awaited_rsps.size(), o);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_EXPLORATION: weight_c = data;
         CSR_VLOSS:       vloss_step = data;
         default:         actions_cfg = data[6:0];
      endcase
   endtask

   // sender side
   always @(posedge clock) begin
      node_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_reqs.size() != 0) begin
            r = pending_reqs.pop_front();
            req_valid        <= 1'b1;
            req_mode         <= r.mode;
            req_action_index <= r.index;
            req_prior_value  <= r.prior;
            req_game_count   <= r.games;
            req_path_value   <= r.path;
            req_action_id    <= r.aid;
            gap_left         <= pick_gap(send_idle);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver side: check each transfer, then decide on stalls
   always @(posedge clock) begin
      node_rsp_type e;
      int g;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsps.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            errors++;
         end else begin
            e = awaited_rsps.pop_front();
            if (rsp_chosen_index !== e.chosen)
               report_mismatch("chosen_index", 32'(rsp_chosen_index), 32'(e.chosen));
            if (rsp_status !== e.status)
               report_mismatch("status", 32'(rsp_status), 32'(e.status));
            if (rsp_node_visits !== e.visits)
               report_mismatch("node_visits", rsp_node_visits, e.visits);
            if (rsp_best_value !== e.best_value)
               report_mismatch("best_value", rsp_best_value, e.best_value);
            if (rsp_best_index !== e.best_index)
               report_mismatch("best_index", 32'(rsp_best_index), 32'(e.best_index));
            if (rsp_best_valid !== e.best_valid)
               report_mismatch("best_valid", 32'(rsp_best_valid), 32'(e.best_valid));
            if (rsp_best_action_id !== e.best_aid)
               report_mismatch("best_action_id", rsp_best_action_id, e.best_aid);
         end
      end
      g = pick_gap(recv_idle);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left      <= 600;
         rsp_ready      <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (g > 0) begin
         hold_left <= g;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // run limit
   initial begin
      #40ms;
      $display("puct_node_select_and_backup_core verification failed");
      $finish;
   end

   // random traffic for one phase, mostly select then backup of the pick
   task automatic random_phase(int count, bit do_hold);
      logic [5:0] pick, dummy;
      logic [7:0] g;
      int r;
      for (int k = 0; k < count; k++) begin
         if (do_hold && k == 2) long_hold_go = 1'b1;
         if (k == count / 2) wait_idle();
         r = $urandom_range(0, 9);
         g = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 4));
         if ($urandom_range(0, 40) == 0) g = 0;
         if (r < 6) begin
            issue(MODE_SELECT, 6'($urandom), 16'($urandom), g, 32'($urandom), $urandom, pick);
            if ($urandom_range(0, 3) != 0)
               issue(MODE_BACKUP, pick, 16'($urandom), g + 8'($urandom_range(0, 1)),
                     32'($urandom), $urandom, dummy);
         end else if (r < 8) begin
            issue(MODE_BACKUP, 6'($urandom), 16'($urandom), g, 32'($urandom), $urandom,
                  dummy);
         end else if (r == 8) begin
            issue(MODE_LOAD, 6'($urandom), 16'($urandom), g, 32'($urandom), $urandom,
                  dummy);
         end else begin
            issue(MODE_NONE, 6'($urandom), 16'($urandom), g, 32'($urandom), $urandom,
                  dummy);
         end
      end
   endtask

   task automatic load_all();
      logic [5:0] dummy;
      for (int i = 0; i < actions_live(); i++)
         issue(MODE_LOAD, 6'(i), 16'($urandom), 8'd1, 0, 0, dummy);
   endtask

   initial begin
      logic [5:0] pick, dummy;
      logic [15:0] c_set [6];
      logic [15:0] v_set [6];
      logic [15:0] a_set [6];
      c_set = '{16'd0, 16'd65535, 16'd1000, 16'd256, 16'd300, 16'd40};
      v_set = '{16'd0, 16'd65535, 16'd128, 16'd0, 16'd500, 16'd65535};
      a_set = '{16'd1, 16'd3, 16'd5, 16'd0, 16'd127, 16'd64};
      weight_c = 256;
      vloss_step = 256;
      actions_cfg = 64;
      visit_sum = 0;
      clear_top();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: small node, field extremes and each special case
      write_csr(CSR_ACTIONS, 16'd4);
      issue(MODE_LOAD, 0, 16'h0000, 8'd1, 0, 0, dummy);
      issue(MODE_LOAD, 1, 16'hFFFF, 8'd1, 0, 0, dummy);
      issue(MODE_LOAD, 2, 16'h8000, 8'd1, 0, 0, dummy);
      issue(MODE_LOAD, 3, 16'h0001, 8'd1, 0, 0, dummy);
      issue(MODE_SELECT, 0, 0, 8'd1, 0, 0, pick);
      issue(MODE_BACKUP, pick, 0, 8'd1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, dummy);
      issue(MODE_SELECT, 0, 0, 8'd255, 0, 0, pick);
      issue(MODE_BACKUP, pick, 0, 8'd255, -32'sh8000_0000, 32'h0, dummy);
      issue(MODE_BACKUP, pick, 0, 8'd1, 32'sh7FFF_FFFF, 32'h1234_5678, dummy);
      issue(MODE_BACKUP, 3, 0, 8'd2, 0, 0, dummy);
      issue(MODE_BACKUP, 6'd63, 0, 8'd1, 0, 0, dummy);
      issue(MODE_LOAD, 6'd10, 16'hFFFF, 8'd1, 0, 0, dummy);
      issue(MODE_NONE, 6'd63, 16'hFFFF, 8'd255, -1, 32'hFFFF_FFFF, dummy);
      issue(MODE_SELECT, 0, 0, 8'd0, 0, 0, pick);
      issue(MODE_SELECT, 0, 0, 8'd3, 0, 0, pick);
      issue(MODE_BACKUP, pick, 0, 8'd3, 32'sh0001_0000, 32'hA5A5_A5A5, dummy);
      issue(MODE_LOAD, 0, 16'h7FFF, 8'd1, 0, 0, dummy);
      issue(MODE_SELECT, 0, 0, 8'd1, 0, 0, pick);
      random_phase(15, 1'b0);
      wait_idle();

      // register settings, extremes included
      for (int p = 0; p < 6; p++) begin
         send_idle = (p != 2);
         recv_idle = (p != 3);
         write_csr(CSR_EXPLORATION, c_set[p]);
         write_csr(CSR_VLOSS, v_set[p]);
         write_csr(CSR_ACTIONS, a_set[p]);
         load_all();
         random_phase((actions_live() > 16) ? 8 : 12, p == 1);
         wait_idle();
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("puct_node_select_and_backup_core verification clean");
      else
         $display("puct_node_select_and_backup_core verification failed");
      $finish;
   end

endmodule
`default_nettype wire

// ===== puct_node_select_and_backup_core.f =====
rtl/puct_pkg.sv
rtl/puct_ram.sv
rtl/puct_divider.sv
rtl/puct_node_select_and_backup_core.sv
sim/testbench.sv
